@@ sv/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg: shared definitions for the first-fit allocator
// Widths, table depth, status and command codes, and the structs that pass
// between the control logic and the row of table cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int ADDR_W     = 16;
	localparam int SIZE_W     = 16;
	localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NO_FIT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_ALLOC  = 1'b1;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic              eval;
		logic              apply;
		logic              is_alloc;
		logic [SIZE_W-1:0] req;
		logic [ADDR_W-1:0] blk_start;
		logic [SIZE_W-1:0] blk_size;
		logic [CNT_W-1:0]  count;
	} cell_ctrl_t;

	// Passed from each cell to the next one up the row.
	typedef struct packed {
		logic              hit;
		logic              shift;
		logic [ADDR_W-1:0] addr;
	} chain_t;

endpackage

`default_nettype wire

@@ sv/ffa_cell.sv @@
// ----------------------------------------------------------------------------
// ffa_cell: one entry of the free-block table
// Holds one start/size pair, tests it against the request, takes part in the
// first-hit chain and moves down one place when an earlier entry is removed.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [ffa_pkg::IDX_W-1:0] idx,
	input  wire ffa_pkg::cell_ctrl_t       ctrl,
	input  wire logic [ffa_pkg::ADDR_W-1:0] nb_start,
	input  wire logic [ffa_pkg::SIZE_W-1:0] nb_size,
	input  wire ffa_pkg::chain_t           chain_in,
	output ffa_pkg::chain_t                chain_out,
	output logic [ffa_pkg::ADDR_W-1:0]     start_val,
	output logic [ffa_pkg::SIZE_W-1:0]     size_val
);

	logic [ffa_pkg::ADDR_W-1:0] start_q;
	logic [ffa_pkg::SIZE_W-1:0] size_q;
	logic                       fit_s1;
	logic [ffa_pkg::CNT_W-1:0]  idx_ext;
	logic                       occupied;
	logic                       sel;
	logic                       empties;

	assign idx_ext  = ffa_pkg::CNT_W'(idx);
	assign occupied = idx_ext < ctrl.count;
	// This cell is the first one that fits when no earlier cell has fit.
	assign sel      = fit_s1 && !chain_in.hit;
	assign empties  = sel && (size_q == ctrl.req);

	assign chain_out.hit   = chain_in.hit | fit_s1;
	assign chain_out.shift = chain_in.shift | empties;
	assign chain_out.addr  = sel ? start_q : chain_in.addr;

	assign start_val = start_q;
	assign size_val  = size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_s1 <= 1'b0;
		end else if (ctrl.eval) begin
			fit_s1 <= occupied && (size_q >= ctrl.req);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.apply) begin
			if (ctrl.is_alloc) begin
				if (chain_in.shift || empties) begin
					start_q <= nb_start;
					size_q  <= nb_size;
				end else if (sel) begin
					start_q <= ffa_pkg::ADDR_W'(start_q + ffa_pkg::ADDR_W'(ctrl.req));
					size_q  <= ffa_pkg::SIZE_W'(size_q - ctrl.req);
				end
			end else if (idx_ext == ctrl.count) begin
				start_q <= ctrl.blk_start;
				size_q  <= ctrl.blk_size;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/first_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_allocator: first-fit free-block table
// An ordered table of free blocks held in a row of cells, with append and
// first-fit allocate commands.
// ----------------------------------------------------------------------------
// Usage. A command word is taken at a rising edge where start is high and
// busy is low; command selects append (block_start, block_size) or allocate
// (request_size). Exactly one result word follows: status and alloc_address
// are valid for the single cycle in which done is high, and the receiver
// cannot stall them, so it must take the word in that cycle.
//
// Operation. Every command runs an evaluate step and then an apply step. In
// the evaluate step every cell compares its size with the request in
// parallel; in the apply step the first hit is resolved along the cell
// chain, the entry is updated or removed (an append writes a new entry after
// the last one), on a removal every later cell moves down one place from its
// neighbor to close the gap, and the result is registered. busy stays high
// from the accepting edge until done is raised, and a new command may be
// accepted in the cycle where done is high.
//
// Reset. arst_n clears the entry count and the controller; the start/size
// pairs in the cells have no reset value and are only read below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_allocator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       command,
	input  wire logic [ffa_pkg::ADDR_W-1:0] block_start,
	input  wire logic [ffa_pkg::SIZE_W-1:0] block_size,
	input  wire logic [ffa_pkg::SIZE_W-1:0] request_size,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [ffa_pkg::ADDR_W-1:0]      alloc_address
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EVAL  = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;

	logic [1:0]                 state_q;
	logic                       cmd_q;
	logic [ffa_pkg::SIZE_W-1:0] req_q;
	logic [ffa_pkg::ADDR_W-1:0] bstart_q;
	logic [ffa_pkg::SIZE_W-1:0] bsize_q;
	logic [ffa_pkg::CNT_W-1:0]  count_q;
	logic                       done_q;
	logic [1:0]                 status_q;
	logic [ffa_pkg::ADDR_W-1:0] addr_q;

	logic                       accept;
	logic                       full;
	logic                       found;
	logic                       removed;
	ffa_pkg::cell_ctrl_t        ctrl;

	ffa_pkg::chain_t            chain [0:ffa_pkg::MAX_BLOCKS];
	logic [ffa_pkg::ADDR_W-1:0] cell_start [0:ffa_pkg::MAX_BLOCKS-1];
	logic [ffa_pkg::SIZE_W-1:0] cell_size  [0:ffa_pkg::MAX_BLOCKS-1];

	assign busy          = (state_q != S_IDLE);
	assign accept        = start && !busy;
	assign full          = (count_q == ffa_pkg::CNT_W'(ffa_pkg::MAX_BLOCKS));
	assign found         = chain[ffa_pkg::MAX_BLOCKS].hit;
	assign removed       = chain[ffa_pkg::MAX_BLOCKS].shift;
	assign done          = done_q;
	assign status        = status_q;
	assign alloc_address = addr_q;

	// Control word seen by every cell. An append into a full table never
	// reaches the cells, so the table stays as it was.
	always_comb begin
		ctrl.eval      = (state_q == S_EVAL);
		ctrl.apply     = (state_q == S_APPLY) && ((cmd_q == ffa_pkg::CMD_ALLOC) || !full);
		ctrl.is_alloc  = (cmd_q == ffa_pkg::CMD_ALLOC);
		ctrl.req       = req_q;
		ctrl.blk_start = bstart_q;
		ctrl.blk_size  = bsize_q;
		ctrl.count     = count_q;
	end

	// The chain starts with no hit, no removal and a zero address, so a miss
	// leaves the granted address at zero.
	assign chain[0] = '0;

	for (genvar i = 0; i < ffa_pkg::MAX_BLOCKS; i++) begin : g_cell
		logic [ffa_pkg::ADDR_W-1:0] nb_start;
		logic [ffa_pkg::SIZE_W-1:0] nb_size;

		// The top cell has no upper neighbor; whatever it takes on a removal
		// lies at or above the new entry count and is never read.
		if (i == ffa_pkg::MAX_BLOCKS - 1) begin : g_top
			assign nb_start = cell_start[i];
			assign nb_size  = cell_size[i];
		end else begin : g_mid
			assign nb_start = cell_start[i+1];
			assign nb_size  = cell_size[i+1];
		end

		ffa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (ffa_pkg::IDX_W'(i)),
			.ctrl      (ctrl),
			.nb_start  (nb_start),
			.nb_size   (nb_size),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.start_val (cell_start[i]),
			.size_val  (cell_size[i])
		);
	end

	// Command registers; they only hold the payload of the accepted word.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= command;
			req_q    <= request_size;
			bstart_q <= block_start;
			bsize_q  <= block_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (cmd_q == ffa_pkg::CMD_APPEND) begin
						if (!full) begin
							count_q <= ffa_pkg::CNT_W'(count_q + 1'b1);
						end
					end else if (removed) begin
						count_q <= ffa_pkg::CNT_W'(count_q - 1'b1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result word, loaded as the command completes.
	always_ff @(posedge clk) begin
		if (state_q == S_APPLY) begin
			if (cmd_q == ffa_pkg::CMD_APPEND) begin
				status_q <= full ? ffa_pkg::ST_FULL : ffa_pkg::ST_OK;
				addr_q   <= '0;
			end else begin
				status_q <= found ? ffa_pkg::ST_OK : ffa_pkg::ST_NO_FIT;
				addr_q   <= chain[ffa_pkg::MAX_BLOCKS].addr;
			end
		end
	end

	// The entry count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ffa_pkg::CNT_W'(ffa_pkg::MAX_BLOCKS))
		else $error("entry count exceeds table depth");

	// A result strobe only follows the apply step.
	a_done_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == S_APPLY)
		else $error("done without a completed command");

	// A table-full answer is only given while the table really is full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ffa_pkg::ST_FULL) |-> full)
		else $error("table full reported with free entries");

	// A removal can only happen when some entry matched.
	a_remove_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && removed) |-> found)
		else $error("entry removed without a match");

endmodule

`default_nettype wire

@@ dv/first_fit_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// first_fit_allocator_tb: self-checking bench for the first-fit allocator
// A short directed table and about a thousand random command words. Each
// accepted word is run through a bench-side copy of the free-block table,
// and every done strobe is checked against the oldest predicted reply.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_allocator_tb;

	// The block answers each word it takes with a single reply. A few spare
	// cycles after the last reply give a stray strobe time to show up.
	localparam int DRAIN_CYCLES   = 8;
	// The limit leaves a wide margin over what a correct run needs, even with
	// the longest sender gaps.
	localparam int LIMIT_CYCLES   = 200000;
	localparam int RANDOM_PER_RUN = 950;
	localparam int NUM_ROWS       = 22;

	// One reply word as the block presents it on its result ports.
	typedef struct {
		logic [1:0]                 status;
		logic [ffa_pkg::ADDR_W-1:0] addr;
	} alloc_reply_t;

	// One row of the directed table. When has_reply is set, the reply is
	// typed in by hand; otherwise it comes from the table copy below.
	typedef struct {
		logic                       cmd;
		logic [ffa_pkg::ADDR_W-1:0] bstart;
		logic [ffa_pkg::SIZE_W-1:0] bsize;
		logic [ffa_pkg::SIZE_W-1:0] req;
		int                         reps;
		bit                         has_reply;
		logic [1:0]                 status;
		logic [ffa_pkg::ADDR_W-1:0] addr;
	} stim_row_t;

	// Every input starts at a known value, with reset held from time zero.
	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       start        = 1'b0;
	logic                       command      = ffa_pkg::CMD_APPEND;
	logic [ffa_pkg::ADDR_W-1:0] block_start  = '0;
	logic [ffa_pkg::SIZE_W-1:0] block_size   = '0;
	logic [ffa_pkg::SIZE_W-1:0] request_size = '0;
	logic                       busy;
	logic                       done;
	logic [1:0]                 status;
	logic [ffa_pkg::ADDR_W-1:0] alloc_address;

	// The bench's own copy of the free-block table. Only entries below
	// table_count are ever read, just as in the block.
	logic [ffa_pkg::ADDR_W-1:0] table_start [ffa_pkg::MAX_BLOCKS];
	logic [ffa_pkg::SIZE_W-1:0] table_size  [ffa_pkg::MAX_BLOCKS];
	int                         table_count;

	// Replies predicted for accepted words and not yet seen on the ports.
	alloc_reply_t reply_q [$];
	alloc_reply_t oldest;
	stim_row_t    directed_rows [NUM_ROWS];

	int idle_pct;
	int errors      = 0;
	int cycle_count = 0;
	int n_appends   = 0;
	int n_full      = 0;
	int n_allocs    = 0;
	int n_grants    = 0;
	int n_no_fit    = 0;

	first_fit_allocator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.block_start   (block_start),
		.block_size    (block_size),
		.request_size  (request_size),
		.done          (done),
		.status        (status),
		.alloc_address (alloc_address)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Applies one command word to the table copy and returns the reply the
	// block owes for it. An append goes after the last entry unless the
	// table is full. An allocate takes the first entry that is large enough,
	// moves its start past the request (wrapping at the address width), and
	// drops the entry once nothing is left of it, closing up the gap.
	function automatic alloc_reply_t first_fit_step(input logic cmd,
			input logic [ffa_pkg::ADDR_W-1:0] bstart,
			input logic [ffa_pkg::SIZE_W-1:0] bsize,
			input logic [ffa_pkg::SIZE_W-1:0] req);
		alloc_reply_t r;
		int           hit;
		int           i;
		r.status = ffa_pkg::ST_OK;
		r.addr   = '0;
		hit      = -1;
		if (cmd == ffa_pkg::CMD_APPEND) begin
			if (table_count >= ffa_pkg::MAX_BLOCKS) begin
				r.status = ffa_pkg::ST_FULL;
			end else begin
				table_start[table_count] = bstart;
				table_size[table_count]  = bsize;
				table_count++;
			end
		end else begin
			for (i = 0; i < table_count; i++) begin
				if (hit < 0 && table_size[i] >= req)
					hit = i;
			end
			if (hit < 0) begin
				r.status = ffa_pkg::ST_NO_FIT;
			end else begin
				r.addr           = table_start[hit];
				table_start[hit] = table_start[hit] + req;
				table_size[hit]  = table_size[hit] - req;
				if (table_size[hit] == '0) begin
					for (i = hit; i + 1 < table_count; i++) begin
						table_start[i] = table_start[i + 1];
						table_size[i]  = table_size[i + 1];
					end
					table_count--;
				end
			end
		end
		return r;
	endfunction

	// Offers one command word and returns in the time step of the edge that
	// takes it, so the caller can put the next word up at once. Before the
	// word goes up, the sender may sit idle for a random number of cycles,
	// drawn cycle by cycle from idle_pct. While busy is high the word is
	// simply held; start is only ever assigned once per time step.
	task automatic issue_word(input logic cmd,
			input logic [ffa_pkg::ADDR_W-1:0] bstart,
			input logic [ffa_pkg::SIZE_W-1:0] bsize,
			input logic [ffa_pkg::SIZE_W-1:0] req,
			input bit has_reply, input logic [1:0] want_status,
			input logic [ffa_pkg::ADDR_W-1:0] want_addr);
		alloc_reply_t r;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			command      <= 1'($urandom_range(0, 1));
			block_start  <= ffa_pkg::ADDR_W'($urandom_range(0, 16'hFFFF));
			block_size   <= ffa_pkg::SIZE_W'($urandom_range(0, 16'hFFFF));
			request_size <= ffa_pkg::SIZE_W'($urandom_range(0, 16'hFFFF));
			@(posedge clk);
		end
		start        <= 1'b1;
		command      <= cmd;
		block_start  <= bstart;
		block_size   <= bsize;
		request_size <= req;
		// busy is read here as it stood before this edge, so the edge that
		// sees it low is the one that takes the word.
		do @(posedge clk); while (busy !== 1'b0);
		r = first_fit_step(cmd, bstart, bsize, req);
		if (cmd == ffa_pkg::CMD_APPEND) begin
			n_appends++;
			if (r.status == ffa_pkg::ST_FULL)
				n_full++;
		end else begin
			n_allocs++;
			if (r.status == ffa_pkg::ST_OK)
				n_grants++;
			else
				n_no_fit++;
		end
		if (has_reply) begin
			r.status = want_status;
			r.addr   = want_addr;
		end
		reply_q.push_back(r);
	endtask

	// Every done strobe must match the oldest reply still owed. The result
	// ports are read at the edge that ends the strobe cycle, before the
	// block updates them.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (reply_q.size() == 0) begin
				$display("%0t: reply with nothing owed: status %0d addr %h",
					$time, status, alloc_address);
				errors++;
			end else begin
				oldest = reply_q.pop_front();
				if (status !== oldest.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, oldest.status, status);
					errors++;
				end
				if (alloc_address !== oldest.addr) begin
					$display("%0t: alloc_address mismatch: expected %h, actual %h",
						$time, oldest.addr, alloc_address);
					errors++;
				end
			end
		end
	end

	// Watchdog: a hung handshake or a lost reply ends the run here.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run did not finish within %0d cycles, %0d replies owed",
			$time, LIMIT_CYCLES, reply_q.size());
		$display("** first_fit_allocator: FAILED **");
		$finish;
	end

	initial begin : stimulus
		logic                       cmd;
		logic [ffa_pkg::ADDR_W-1:0] bstart;
		logic [ffa_pkg::SIZE_W-1:0] bsize;
		logic [ffa_pkg::SIZE_W-1:0] req;
		int                         idle_plan [3];
		int                         phase;
		int                         n;
		int                         k;
		int                         row;

		table_count = 0;
		idle_pct    = 0;
		// Sender idle share per random phase: back to back, mostly idle, and
		// lightly idle. The receiver side has no stall to exercise.
		idle_plan = '{0, 79, 18};

		// The directed table. It opens on an empty table, walks the special
		// cases (zero request, zero-size block, exact fit that removes an
		// entry, start address wrapping past the top), then fills the table,
		// gets refused, and frees space again.
		directed_rows = '{
			// Empty table: nothing can fit, not even a zero request.
			'{ffa_pkg::CMD_ALLOC, 16'h0000, 16'h0000, 16'h0000, 1, 1,
				ffa_pkg::ST_NO_FIT, 16'h0000},
			'{ffa_pkg::CMD_ALLOC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1,
				ffa_pkg::ST_NO_FIT, 16'h0000},
			// Appends always answer with a zero address.
			'{ffa_pkg::CMD_APPEND, 16'h0000, 16'h0010, 16'hFFFF, 1, 1,
				ffa_pkg::ST_OK, 16'h0000},
			'{ffa_pkg::CMD_APPEND, 16'hFFF0, 16'h0020, 16'h0000, 1, 1,
				ffa_pkg::ST_OK, 16'h0000},
			'{ffa_pkg::CMD_APPEND, 16'h1234, 16'h0000, 16'h0000, 1, 1,
				ffa_pkg::ST_OK, 16'h0000},
			'{ffa_pkg::CMD_APPEND, 16'h8000, 16'hFFFF, 16'h0000, 1, 1,
				ffa_pkg::ST_OK, 16'h0000},
			// Zero request grants the first entry and leaves it alone.
			'{ffa_pkg::CMD_ALLOC, 16'hAAAA, 16'h5555, 16'h0000, 1, 0,
				ffa_pkg::ST_OK, 16'h0000},
			// Exact fit removes the first entry.
			'{ffa_pkg::CMD_ALLOC, 16'h5555, 16'hAAAA, 16'h0010, 1, 0,
				ffa_pkg::ST_OK, 16'h0000},
			// Partial grant whose new start wraps past the top of memory.
			'{ffa_pkg::CMD_ALLOC, 16'h0000, 16'h0000, 16'h0018, 1, 0,
				ffa_pkg::ST_OK, 16'h0000},
			// Skips a short entry and the zero-size one.
			'{ffa_pkg::CMD_ALLOC, 16'h0000, 16'h0000, 16'h0010, 1, 0,
				ffa_pkg::ST_OK, 16'h0000},
			'{ffa_pkg::CMD_ALLOC, 16'h0000, 16'h0000, 16'h0000, 1, 0,
				ffa_pkg::ST_OK, 16'h0000},
			'{ffa_pkg::CMD_ALLOC, 16'h0000, 16'h0000, 16'h0008, 1, 0,
				ffa_pkg::ST_OK, 16'h0000},
			// Zero request reaching the zero-size block removes it.
			'{ffa_pkg::CMD_ALLOC, 16'h0000, 16'h0000, 16'h0000, 1, 0,
				ffa_pkg::ST_OK, 16'h0000},
			'{ffa_pkg::CMD_ALLOC, 16'h0000, 16'h0000, 16'hFFFF, 1, 1,
				ffa_pkg::ST_NO_FIT, 16'h0000},
			'{ffa_pkg::CMD_ALLOC, 16'h0000, 16'h0000, 16'hFFEF, 1, 0,
				ffa_pkg::ST_OK, 16'h0000},
			'{ffa_pkg::CMD_ALLOC, 16'h0000, 16'h0000, 16'h0001, 1, 1,
				ffa_pkg::ST_NO_FIT, 16'h0000},
			// Fill the table with the largest blocks, then get refused.
			'{ffa_pkg::CMD_APPEND, 16'hFFFF, 16'hFFFF, 16'h0000,
				ffa_pkg::MAX_BLOCKS, 1, ffa_pkg::ST_OK, 16'h0000},
			'{ffa_pkg::CMD_APPEND, 16'h0000, 16'h0001, 16'h0000, 1, 1,
				ffa_pkg::ST_FULL, 16'h0000},
			'{ffa_pkg::CMD_ALLOC, 16'h0000, 16'h0000, 16'hFFFF, 2, 0,
				ffa_pkg::ST_OK, 16'h0000},
			'{ffa_pkg::CMD_APPEND, 16'h5555, 16'hAAAA, 16'h0000, 1, 1,
				ffa_pkg::ST_OK, 16'h0000},
			'{ffa_pkg::CMD_ALLOC, 16'hFFFF, 16'hFFFF, 16'h0001, 1, 0,
				ffa_pkg::ST_OK, 16'h0000},
			'{ffa_pkg::CMD_ALLOC, 16'h0000, 16'h0000, 16'hAAAA, 1, 0,
				ffa_pkg::ST_OK, 16'h0000}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < NUM_ROWS; row++) begin
			repeat (directed_rows[row].reps)
				issue_word(directed_rows[row].cmd, directed_rows[row].bstart,
					directed_rows[row].bsize, directed_rows[row].req,
					directed_rows[row].has_reply, directed_rows[row].status,
					directed_rows[row].addr);
		end

		// Random part. Appends are favored while the table is nearly empty so
		// that allocates usually have something to search; when the table is
		// full, appends still come often enough to be refused. Most block
		// sizes are small so entries get used up and removed; requests are
		// often the exact size of a live entry, or a slice of one.
		for (phase = 0; phase < 3; phase++) begin
			idle_pct = idle_plan[phase];
			for (n = 0; n < RANDOM_PER_RUN / 3 + 1; n++) begin
				if (table_count < 4)
					cmd = ($urandom_range(0, 99) < 70) ?
						ffa_pkg::CMD_APPEND : ffa_pkg::CMD_ALLOC;
				else
					cmd = ($urandom_range(0, 99) < 45) ?
						ffa_pkg::CMD_APPEND : ffa_pkg::CMD_ALLOC;
				bstart = ffa_pkg::ADDR_W'($urandom_range(0, 16'hFFFF));
				case ($urandom_range(0, 15))
					0:       bsize = '0;
					1, 2:    bsize = ffa_pkg::SIZE_W'($urandom_range(0, 16'hFFFF));
					default: bsize = ffa_pkg::SIZE_W'($urandom_range(1, 64));
				endcase
				k = (table_count > 0) ? $urandom_range(0, table_count - 1) : 0;
				case ($urandom_range(0, 7))
					0:       req = '0;
					1, 2:    req = (table_count > 0) ? table_size[k] : 16'h0001;
					3:       req = (table_count > 0 && table_size[k] > 0) ?
						ffa_pkg::SIZE_W'($urandom_range(1, table_size[k])) : 16'h0001;
					4, 5:    req = ffa_pkg::SIZE_W'($urandom_range(1, 32));
					6:       req = ffa_pkg::SIZE_W'($urandom_range(0, 16'hFFFF));
					default: req = 16'hFFFF - ffa_pkg::SIZE_W'($urandom_range(0, 3));
				endcase
				issue_word(cmd, bstart, bsize, req, 1'b0, ffa_pkg::ST_OK, '0);
			end
		end

		start <= 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d appends (%0d refused on a full table) and %0d allocates",
			n_appends, n_full, n_allocs);
		$display("(%0d granted, %0d without a fit), %0d mismatches found.",
			n_grants, n_no_fit, errors);
		if (errors == 0)
			$display("** first_fit_allocator: PASSED **");
		else
			$display("** first_fit_allocator: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
sv/ffa_pkg.sv
sv/ffa_cell.sv
sv/first_fit_allocator.sv
dv/first_fit_allocator_tb.sv
